// File: rtl/core/plst_pkg.sv
// Shared types, sizes and request codes for the positional list store.
`default_nettype none

package plst_pkg;

  // Number of cells in the list.
  localparam int CAPACITY = 16;
  // Width of a cell index and of the entry count (0..CAPACITY).
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Field widths of the request and result items.
  localparam int KIND_W = 3;
  localparam int POS_W  = 5;
  localparam int WORD_W = 32;
  localparam int LEN_W  = 5;
  // Width for comparing a position against the count and count + 1.
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_GET     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REPLACE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

  // One request item.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] value;
  } plst_req_t;

  // One result item.
  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] data;
    logic [LEN_W-1:0]  length;
    logic              empty_res;
  } plst_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;  // execute the presented request and load the result
  } plst_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/plst_ctrl.sv
// Handshake controller for the positional list store.
`default_nettype none

module plst_ctrl
  import plst_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output plst_cmd_t      cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state;
  logic state_next;

  // A new item is taken when the result register is free or being emptied.
  always_comb begin
    in_ready   = (state == ST_IDLE) || out_ready;
    cmd.exec   = in_valid && in_ready;
    out_valid  = (state == ST_HOLD);
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.exec) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (cmd.exec) begin
          state_next = ST_HOLD;
        end else if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/plst_dp.sv
// Cell array, entry count and result register of the positional list store.
`default_nettype none

module plst_dp
  import plst_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire plst_cmd_t cmd,
  input  wire plst_req_t req,
  output plst_res_t      res
);

  logic [WORD_W-1:0] entries [CAPACITY];
  logic [WORD_W-1:0] entries_next [CAPACITY];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  plst_res_t         res_next;

  logic [CMP_W-1:0]  pos_w;
  logic [CMP_W-1:0]  cnt_w;
  logic [IDX_W-1:0]  idx;
  logic              in_list;
  logic              ins_fits;
  logic              do_ins;
  logic              do_rem;
  logic              do_rep;
  logic [WORD_W-1:0] rd_word;

  // Position checks against the current count.
  always_comb begin
    pos_w    = CMP_W'(req.position);
    cnt_w    = CMP_W'(count);
    idx      = IDX_W'(pos_w - CMP_W'(1));
    in_list  = (pos_w != '0) && (pos_w <= cnt_w);
    ins_fits = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1)) &&
               (cnt_w < CMP_W'(CAPACITY));
    rd_word  = entries[idx];
  end

  // Request decode: acceptance, returned word and new count.
  always_comb begin
    do_ins            = 1'b0;
    do_rem            = 1'b0;
    do_rep            = 1'b0;
    count_next        = count;
    res_next.ok       = 1'b0;
    res_next.data     = '0;
    unique case (req.kind)
      KIND_GET: begin
        if (in_list) begin
          res_next.ok   = 1'b1;
          res_next.data = rd_word;
        end
      end
      KIND_INSERT: begin
        if (ins_fits) begin
          res_next.ok = 1'b1;
          do_ins      = 1'b1;
          count_next  = count + CNT_W'(1);
        end
      end
      KIND_REMOVE: begin
        if (in_list) begin
          res_next.ok = 1'b1;
          do_rem      = 1'b1;
          count_next  = count - CNT_W'(1);
        end
      end
      KIND_REPLACE: begin
        if (in_list) begin
          res_next.ok   = 1'b1;
          res_next.data = rd_word;
          do_rep        = 1'b1;
        end
      end
      KIND_CLEAR: begin
        res_next.ok = 1'b1;
        count_next  = '0;
      end
      default: begin
        res_next.ok = 1'b0;
      end
    endcase
    res_next.length    = LEN_W'(count_next);
    res_next.empty_res = (count_next == '0);
  end

  // Each cell picks its own next word by comparing its index with the position.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_next[i] = entries[i];
      if ((do_ins || do_rep) && (IDX_W'(i) == idx)) begin
        entries_next[i] = req.value;
      end else if (do_ins && (IDX_W'(i) > idx)) begin
        entries_next[i] = entries[(i > 0) ? i - 1 : 0];
      end else if (do_rem && (IDX_W'(i) >= idx) && (i < CAPACITY - 1)) begin
        entries_next[i] = entries[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  // Cell array and result register.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        entries[i] <= entries_next[i];
      end
      res <= res_next;
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/positional_list_store_unit.sv
// Top level of the positional list store: controller plus cell datapath.
// The block holds an ordered list of up to 16 words addressed by 1-based
// position and serves get, insert, remove, replace and clear requests. Every
// request produces exactly one result item carrying ok, the returned word, the
// new length and an empty flag. For each accepted request, all cells
// compare their index with the position in parallel and shift or load at the
// acceptance edge, and the result is loaded into an output register. A new
// item is accepted while the previous result waits, as long as that result is
// taken in the same cycle, so one item per cycle is sustained when the output
// side is always ready. Reset empties the list at once; no clearing pass runs.
`default_nettype none

module positional_list_store_unit
  import plst_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire plst_req_t in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output plst_res_t      out_data
);

  plst_cmd_t cmd;

  // Handshake control.
  plst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // List cells and result register.
  plst_dp u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (in_data),
    .res (out_data)
  );

`ifndef ASSERT_OFF
  // No result is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // A waiting result that is not taken blocks new items.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("item accepted over an untaken result");

  // A rejected request never returns a word.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.ok) |-> (out_data.data == '0))
    else $error("rejected request returned data");

  // The empty flag agrees with the reported length.
  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.empty_res == (out_data.length == '0)))
    else $error("empty flag disagrees with length");
`endif

endmodule

`default_nettype wire
